// ===== hw/rtl/bimt_pkg.sv =====
// ============================================================================
// bimt_pkg
// Shared types and codes for the bidirectional ID map table: operation,
// kind and status codes, and the query token passed along the cell chain.
// ============================================================================
package bimt_pkg;

    localparam int unsigned DEFAULT_ENTRIES = 64;
    localparam int unsigned ID_W            = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_USER    = 2'd0,
        KIND_GROUP   = 2'd1,
        KIND_PROJECT = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_INSERTED        = 4'd0,
        ST_EXISTS          = 4'd1,
        ST_CLIENT_CONFLICT = 4'd2,
        ST_FS_CONFLICT     = 4'd3,
        ST_FOUND           = 4'd4,
        ST_NOT_FOUND       = 4'd5,
        ST_DELETED         = 4'd6,
        ST_BAD_KIND        = 4'd7,
        ST_FULL            = 4'd8,
        ST_CLEARED         = 4'd9
    } status_t;

    // Query token; the hit fields accumulate as it walks the chain
    typedef struct packed {
        logic            active;
        op_t             op;
        kind_t           kind;
        logic            dir;
        logic [ID_W-1:0] ckey;
        logic [ID_W-1:0] fkey;
        logic            c_hit;
        logic [ID_W-1:0] c_cid;
        logic [ID_W-1:0] c_fid;
        logic            f_hit;
        logic [ID_W-1:0] f_cid;
        logic [ID_W-1:0] f_fid;
        logic            del_hit;
        logic            free_hit;
    } token_t;

    // Entry write broadcast at the end of an insert
    typedef struct packed {
        logic            en;
        kind_t           kind;
        logic [ID_W-1:0] cid;
        logic [ID_W-1:0] fid;
    } entry_wr_t;

endpackage

// ===== hw/rtl/bidirectional_id_map_table.sv =====
// ============================================================================
// bidirectional_id_map_table
// Table of client/filesystem ID pairs per kind, searchable both ways.
// ============================================================================
// Usage:
//   Command channel: drive op, id_kind, direction, cli_id, fs_id and
//   search_id with start high; the transaction is taken on a clock edge where
//   start is high and busy is low. busy stays high until the result is out.
//   Result channel: done is high for exactly one cycle with status,
//   match_cli_id and match_fs_id valid. The receiver cannot stall it;
//   every command yields exactly one result.
//   Each transaction walks a chain of ENTRIES cells, one cell per cycle,
//   and done is registered from the token as it leaves the chain. busy
//   drops as done rises, so the next command is taken at the edge that
//   ends the done cycle: only one transaction is in the table at a time.
//   The chain length sets how long each transaction takes.
//   Insert writes its free entry by a broadcast on the cycle the token
//   leaves the chain; delete and clear act in place as the token passes.
//   Reset: all entries invalid (empty table), busy and done low.
// ============================================================================
module bidirectional_id_map_table #(
    parameter int unsigned ENTRIES = bimt_pkg::DEFAULT_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  op,
    input  logic [1:0]                  id_kind,
    input  logic                        direction,
    input  logic [bimt_pkg::ID_W-1:0]   cli_id,
    input  logic [bimt_pkg::ID_W-1:0]   fs_id,
    input  logic [bimt_pkg::ID_W-1:0]   search_id,
    output logic                        done,
    output logic [3:0]                  status,
    output logic [bimt_pkg::ID_W-1:0]   match_cli_id,
    output logic [bimt_pkg::ID_W-1:0]   match_fs_id
);
    import bimt_pkg::*;

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    logic   accept;
    logic   busy_reg;
    logic   active_in_reg;
    token_t tok_in_reg;
    token_t tok_in_next;
    token_t tok_head;

    token_t           tok      [ENTRIES+1];
    logic [IDX_W-1:0] free_idx [ENTRIES+1];

    token_t           tok_end;
    entry_wr_t        wr;
    logic [IDX_W-1:0] wr_idx;

    logic              done_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [ID_W-1:0]   mcid_reg;
    logic [ID_W-1:0]   mcid_next;
    logic [ID_W-1:0]   mfid_reg;
    logic [ID_W-1:0]   mfid_next;

    assign accept = start && !busy_reg;

    // Build the query token from the command
    always_comb
    begin
        tok_in_next          = '0;
        tok_in_next.active   = accept;
        tok_in_next.op       = op_t'(op);
        tok_in_next.kind     = kind_t'(id_kind);
        tok_in_next.dir      = direction;
        if (op_t'(op) == OP_LOOKUP)
        begin
            tok_in_next.ckey = search_id;
            tok_in_next.fkey = search_id;
        end
        else
        begin
            tok_in_next.ckey = cli_id;
            tok_in_next.fkey = fs_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_in_reg <= 1'b0;
        end
        else
        begin
            active_in_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_in_reg <= tok_in_next;
    end

    // Head of the chain takes the reset-clean active bit
    always_comb
    begin
        tok_head        = tok_in_reg;
        tok_head.active = active_in_reg;
    end

    assign tok[0]      = tok_head;
    assign free_idx[0] = '0;

    // Cell chain
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        bimt_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .up_tok      (tok[g]),
            .up_free_idx (free_idx[g]),
            .dn_tok      (tok[g+1]),
            .dn_free_idx (free_idx[g+1]),
            .wr          (wr),
            .wr_idx      (wr_idx)
        );
    end

    assign tok_end = tok[ENTRIES];

    // Resolve the transaction as the token leaves the chain
    always_comb
    begin
        status_next = ST_NOT_FOUND;
        mcid_next   = '0;
        mfid_next   = '0;
        wr.en       = 1'b0;
        wr.kind     = tok_end.kind;
        wr.cid      = tok_end.ckey;
        wr.fid      = tok_end.fkey;
        wr_idx      = free_idx[ENTRIES];
        if (tok_end.op == OP_CLEAR)
        begin
            status_next = ST_CLEARED;
        end
        else if (tok_end.kind == KIND_BAD)
        begin
            status_next = ST_BAD_KIND;
        end
        else
        begin
            case (tok_end.op)
                OP_INSERT:
                begin
                    if (tok_end.c_hit && tok_end.f_hit)
                    begin
                        status_next = ST_EXISTS;
                    end
                    else if (tok_end.c_hit)
                    begin
                        status_next = ST_CLIENT_CONFLICT;
                        mcid_next   = tok_end.c_cid;
                        mfid_next   = tok_end.c_fid;
                    end
                    else if (tok_end.f_hit)
                    begin
                        status_next = ST_FS_CONFLICT;
                        mcid_next   = tok_end.f_cid;
                        mfid_next   = tok_end.f_fid;
                    end
                    else if (tok_end.free_hit)
                    begin
                        status_next = ST_INSERTED;
                        wr.en       = tok_end.active;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                OP_DELETE:
                begin
                    status_next = tok_end.del_hit ? ST_DELETED : ST_NOT_FOUND;
                end
                OP_LOOKUP:
                begin
                    if (!tok_end.dir && tok_end.c_hit)
                    begin
                        status_next = ST_FOUND;
                        mcid_next   = tok_end.c_cid;
                        mfid_next   = tok_end.c_fid;
                    end
                    else if (tok_end.dir && tok_end.f_hit)
                    begin
                        status_next = ST_FOUND;
                        mcid_next   = tok_end.f_cid;
                        mfid_next   = tok_end.f_fid;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_next = ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Busy and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tok_end.active;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tok_end.active)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (tok_end.active)
        begin
            status_reg <= status_next;
            mcid_reg   <= mcid_next;
            mfid_reg   <= mfid_next;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign status       = status_reg;
    assign match_cli_id = mcid_reg;
    assign match_fs_id  = mfid_reg;

endmodule

// ===== hw/rtl/bimt_cell.sv =====
// ============================================================================
// bimt_cell
// One table entry plus one token stage. Compares the passing token against
// the stored pair, records hits, performs in-place delete/clear, and loads
// a new pair when the insert write targets this cell's index.
// ============================================================================
module bimt_cell #(
    parameter int unsigned IDX_W = 6,
    parameter int unsigned INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bimt_pkg::token_t    up_tok,
    input  logic [IDX_W-1:0]    up_free_idx,
    output bimt_pkg::token_t    dn_tok,
    output logic [IDX_W-1:0]    dn_free_idx,
    input  bimt_pkg::entry_wr_t wr,
    input  logic [IDX_W-1:0]    wr_idx
);
    import bimt_pkg::*;

    logic            valid_reg;
    kind_t           kind_reg;
    logic [ID_W-1:0] cid_reg;
    logic [ID_W-1:0] fid_reg;

    token_t           tok_next;
    logic [IDX_W-1:0] free_idx_next;
    logic             active_reg;
    token_t           tok_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic kind_match;
    logic c_match;
    logic f_match;
    logic wr_here;
    logic del_here;
    logic clr_here;

    // Entry compare
    assign kind_match = valid_reg && (kind_reg == up_tok.kind);
    assign c_match    = kind_match && (cid_reg == up_tok.ckey);
    assign f_match    = kind_match && (fid_reg == up_tok.fkey);
    assign wr_here    = wr.en && (wr_idx == IDX_W'(INDEX));
    assign del_here   = up_tok.active && (up_tok.op == OP_DELETE) && !up_tok.del_hit
                        && c_match && f_match;
    assign clr_here   = up_tok.active && (up_tok.op == OP_CLEAR);

    // Token update; first hit in chain order wins
    always_comb
    begin
        tok_next      = up_tok;
        free_idx_next = up_free_idx;
        if (c_match && !up_tok.c_hit)
        begin
            tok_next.c_hit = 1'b1;
            tok_next.c_cid = cid_reg;
            tok_next.c_fid = fid_reg;
        end
        if (f_match && !up_tok.f_hit)
        begin
            tok_next.f_hit = 1'b1;
            tok_next.f_cid = cid_reg;
            tok_next.f_fid = fid_reg;
        end
        if (del_here)
        begin
            tok_next.del_hit = 1'b1;
        end
        if (!valid_reg && !up_tok.free_hit)
        begin
            tok_next.free_hit = 1'b1;
            free_idx_next     = IDX_W'(INDEX);
        end
    end

    // Entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= 1'b1;
        end
        else if (del_here || clr_here)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            kind_reg <= wr.kind;
            cid_reg  <= wr.cid;
            fid_reg  <= wr.fid;
        end
    end

    // Token stage: active bit is control, rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= up_tok.active;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg      <= tok_next;
        free_idx_reg <= free_idx_next;
    end

    // Downstream token carries the reset-clean active bit
    always_comb
    begin
        dn_tok        = tok_reg;
        dn_tok.active = active_reg;
    end

    assign dn_free_idx = free_idx_reg;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bidirectional ID map table. A queue of commands
// is built up front: a directed opener, then random pool traffic and table
// fill bursts. The driver feeds the queue to the command port with random
// gaps. The monitor mirrors the table in a local copy and checks every done
// strobe against the oldest predicted reply.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bimt_pkg::*;

    localparam int unsigned TBL_ENTRIES = DEFAULT_ENTRIES;
    localparam int          POOL_SIZE   = 32;
    localparam int          RAND_ITEMS  = 1800;
    localparam int          STALL_LIMIT = 2000;

    typedef struct {
        op_t             op;
        kind_t           kind;
        logic            dir;
        logic [ID_W-1:0] cid;
        logic [ID_W-1:0] fid;
        logic [ID_W-1:0] sid;
    } map_cmd_t;

    typedef struct {
        status_t         status;
        logic [ID_W-1:0] mcid;
        logic [ID_W-1:0] mfid;
    } map_reply_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [1:0]      op = OP_LOOKUP;
    logic [1:0]      id_kind = KIND_USER;
    logic            direction = 1'b0;
    logic [ID_W-1:0] cli_id = '0;
    logic [ID_W-1:0] fs_id = '0;
    logic [ID_W-1:0] search_id = '0;
    logic            done;
    logic [3:0]      status;
    logic [ID_W-1:0] match_cli_id;
    logic [ID_W-1:0] match_fs_id;

    bidirectional_id_map_table #(
        .ENTRIES(TBL_ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .id_kind(id_kind),
        .direction(direction),
        .cli_id(cli_id),
        .fs_id(fs_id),
        .search_id(search_id),
        .done(done),
        .status(status),
        .match_cli_id(match_cli_id),
        .match_fs_id(match_fs_id)
    );

    // Shadow copy of the table
    logic            tbl_valid [TBL_ENTRIES];
    kind_t           tbl_kind  [TBL_ENTRIES];
    logic [ID_W-1:0] tbl_cid   [TBL_ENTRIES];
    logic [ID_W-1:0] tbl_fid   [TBL_ENTRIES];

    map_cmd_t   cmd_backlog[$];
    map_reply_t replies_due[$];
    logic [ID_W-1:0] pool_cid [POOL_SIZE];
    logic [ID_W-1:0] pool_fid [POOL_SIZE];

    int   err_cnt = 0;
    int   total_items = 0;
    int   issued = 0;
    int   gap_left = 0;
    int   stall_cnt = 0;
    logic took_cmd = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table mirror
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < TBL_ENTRIES; i++) tbl_valid[i] = 1'b0;
    end

    // First valid entry of this kind whose chosen side holds id, else -1
    function automatic int tbl_find(kind_t k, logic fs_side, logic [ID_W-1:0] id);
        for (int i = 0; i < TBL_ENTRIES; i++)
            if (tbl_valid[i] && tbl_kind[i] == k &&
                (fs_side ? tbl_fid[i] : tbl_cid[i]) == id)
                return i;
        return -1;
    endfunction

    // Applies one command to the mirror and returns the reply it must cause
    function automatic map_reply_t predict_map_reply(map_cmd_t c);
        map_reply_t r;
        int ci, fi, slot;
        r.status = ST_NOT_FOUND;
        r.mcid = '0;
        r.mfid = '0;
        if (c.op == OP_CLEAR) begin
            for (int i = 0; i < TBL_ENTRIES; i++) tbl_valid[i] = 1'b0;
            r.status = ST_CLEARED;
        end else if (c.kind == KIND_BAD) begin
            r.status = ST_BAD_KIND;
        end else begin
            case (c.op)
                OP_INSERT:
                begin
                    ci = tbl_find(c.kind, 1'b0, c.cid);
                    fi = tbl_find(c.kind, 1'b1, c.fid);
                    if (ci >= 0 && fi >= 0) begin
                        r.status = ST_EXISTS;
                    end else if (ci >= 0) begin
                        r.status = ST_CLIENT_CONFLICT;
                        r.mcid = tbl_cid[ci];
                        r.mfid = tbl_fid[ci];
                    end else if (fi >= 0) begin
                        r.status = ST_FS_CONFLICT;
                        r.mcid = tbl_cid[fi];
                        r.mfid = tbl_fid[fi];
                    end else begin
                        // lowest free slot wins
                        slot = -1;
                        for (int i = 0; i < TBL_ENTRIES; i++)
                            if (slot < 0 && !tbl_valid[i]) slot = i;
                        if (slot < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            tbl_valid[slot] = 1'b1;
                            tbl_kind[slot]  = c.kind;
                            tbl_cid[slot]   = c.cid;
                            tbl_fid[slot]   = c.fid;
                            r.status = ST_INSERTED;
                        end
                    end
                end
                OP_DELETE:
                begin
                    slot = -1;
                    for (int i = 0; i < TBL_ENTRIES; i++)
                        if (slot < 0 && tbl_valid[i] && tbl_kind[i] == c.kind &&
                            tbl_cid[i] == c.cid && tbl_fid[i] == c.fid)
                            slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b0;
                        r.status = ST_DELETED;
                    end
                end
                default:
                begin
                    ci = tbl_find(c.kind, c.dir, c.sid);
                    if (ci >= 0) begin
                        r.status = ST_FOUND;
                        r.mcid = tbl_cid[ci];
                        r.mfid = tbl_fid[ci];
                    end
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(op_t o, kind_t k, logic d, logic [ID_W-1:0] c,
                             logic [ID_W-1:0] f, logic [ID_W-1:0] s);
        map_cmd_t m;
        m.op = o;
        m.kind = k;
        m.dir = d;
        m.cid = c;
        m.fid = f;
        m.sid = s;
        cmd_backlog.push_back(m);
    endtask

    function automatic kind_t pick_kind();
        if ($urandom_range(0, 99) < 6) return KIND_BAD;
        return kind_t'($urandom_range(0, 2));
    endfunction

    // Pool traffic: ids mostly drawn from a small set so hits are common
    task automatic gen_mixed(int n);
        int r, j, k;
        logic d;
        logic [ID_W-1:0] c, f, s;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            j = $urandom_range(0, POOL_SIZE - 1);
            k = $urandom_range(0, POOL_SIZE - 1);
            d = 1'($urandom_range(0, 1));
            c = pool_cid[j];
            f = ($urandom_range(0, 99) < 80) ? pool_fid[j] : pool_fid[k];
            s = $urandom;
            if (r < 40) begin
                if ($urandom_range(0, 9) == 0) begin
                    c = $urandom;
                    f = $urandom;
                end
                queue_cmd(OP_INSERT, pick_kind(), d, c, f, s);
            end else if (r < 60) begin
                queue_cmd(OP_DELETE, pick_kind(), d, c, f, s);
            end else if (r < 96) begin
                if ($urandom_range(0, 99) >= 15) s = d ? pool_fid[j] : pool_cid[j];
                queue_cmd(OP_LOOKUP, pick_kind(), d, $urandom, $urandom, s);
            end else begin
                queue_cmd(OP_CLEAR, kind_t'($urandom_range(0, 3)), d, c, f, s);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Command list, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int burst_len;
        pool_cid[0] = '0;
        pool_fid[0] = '1;
        pool_cid[1] = '1;
        pool_fid[1] = '0;
        for (int i = 2; i < POOL_SIZE; i++) begin
            pool_cid[i] = $urandom;
            pool_fid[i] = $urandom;
        end

        // directed opener
        queue_cmd(OP_LOOKUP, KIND_USER, 1'b0, '0, '0, '0);          // empty table
        queue_cmd(OP_INSERT, KIND_USER, 1'b0, '0, '1, '1);
        queue_cmd(OP_INSERT, KIND_GROUP, 1'b1, '1, '0, '0);
        queue_cmd(OP_INSERT, KIND_USER, 1'b0, '0, '1, '0);          // both present
        queue_cmd(OP_INSERT, KIND_USER, 1'b0, '0, 32'd5, '0);       // client side taken
        queue_cmd(OP_INSERT, KIND_USER, 1'b1, 32'd7, '1, '0);       // fs side taken
        queue_cmd(OP_INSERT, KIND_USER, 1'b0, '1, '0, '0);
        queue_cmd(OP_INSERT, KIND_USER, 1'b0, '0, '0, '1);          // ids in two entries
        queue_cmd(OP_INSERT, KIND_PROJECT, 1'b0, '0, '0, '0);
        queue_cmd(OP_LOOKUP, KIND_USER, 1'b0, '1, '1, '0);
        queue_cmd(OP_LOOKUP, KIND_USER, 1'b1, '1, '1, '0);
        queue_cmd(OP_LOOKUP, KIND_GROUP, 1'b1, '0, '0, '0);
        queue_cmd(OP_LOOKUP, KIND_PROJECT, 1'b0, '0, '0, 32'd12345);
        queue_cmd(OP_INSERT, KIND_BAD, 1'b0, 32'd1, 32'd2, '0);
        queue_cmd(OP_DELETE, KIND_BAD, 1'b0, '0, '1, '0);
        queue_cmd(OP_LOOKUP, KIND_BAD, 1'b1, '0, '0, '0);
        queue_cmd(OP_DELETE, KIND_USER, 1'b0, '0, '0, '1);          // pair absent
        queue_cmd(OP_DELETE, KIND_USER, 1'b1, '0, '1, '0);
        queue_cmd(OP_INSERT, KIND_USER, 1'b0, 32'h1234_5678, 32'h9abc_def0, '0);
        queue_cmd(OP_LOOKUP, KIND_USER, 1'b1, '0, '0, 32'h9abc_def0);
        queue_cmd(OP_CLEAR, KIND_BAD, 1'b1, '1, '1, '1);
        queue_cmd(OP_LOOKUP, KIND_USER, 1'b0, '0, '0, '1);

        // random part: pool traffic and fill bursts that can run into a full table
        total_items = cmd_backlog.size() + RAND_ITEMS;
        while (cmd_backlog.size() < total_items) begin
            if ($urandom_range(0, 3) != 0) begin
                gen_mixed($urandom_range(20, 60));
            end else begin
                burst_len = $urandom_range(TBL_ENTRIES - 4, TBL_ENTRIES + 6);
                for (int i = 0; i < burst_len; i++)
                    queue_cmd(OP_INSERT, kind_t'($urandom_range(0, 2)),
                              1'b0, $urandom, $urandom, $urandom);
                gen_mixed(12);
                if ($urandom_range(0, 1) == 1)
                    queue_cmd(OP_CLEAR, kind_t'($urandom_range(0, 3)),
                              1'b0, $urandom, $urandom, $urandom);
            end
        end
        total_items = cmd_backlog.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start || replies_due.size() != 0)
            @(posedge clk);
        repeat (TBL_ENTRIES + 8) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: next command at the falling edge, sender gaps by phase
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        map_cmd_t c;
        logic nxt_start;
        int idle_pct;
        if (rst_n) begin
            idle_pct = (issued < total_items / 3) ? 15 :
                       (issued < 2 * total_items / 3) ? 78 : 0;
            nxt_start = start;
            if (start && took_cmd) begin
                nxt_start = 1'b0;
                // occasional long gap so the next start lands anywhere in a scan
                if ($urandom_range(0, 99) < idle_pct / 3)
                    gap_left = $urandom_range(1, TBL_ENTRIES + 8);
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0 &&
                             $urandom_range(0, 99) >= idle_pct) begin
                    c = cmd_backlog.pop_front();
                    op <= c.op;
                    id_kind <= c.kind;
                    direction <= c.dir;
                    cli_id <= c.cid;
                    fs_id <= c.fid;
                    search_id <= c.sid;
                    issued++;
                    nxt_start = 1'b1;
                end
            end
            start <= nxt_start;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check replies, then predict for an accepted transaction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        map_cmd_t c;
        map_reply_t e;
        if (rst_n) begin
            if (done) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected done, status %0d client %h fs %h",
                             $time, status, match_cli_id, match_fs_id);
                    err_cnt++;
                end else begin
                    e = replies_due.pop_front();
                    if (status !== e.status) begin
                        $display("%0t: status expected %0d (%s) got %0d",
                                 $time, e.status, e.status.name(), status);
                        err_cnt++;
                    end
                    if (match_cli_id !== e.mcid) begin
                        $display("%0t: match_cli_id expected %h got %h",
                                 $time, e.mcid, match_cli_id);
                        err_cnt++;
                    end
                    if (match_fs_id !== e.mfid) begin
                        $display("%0t: match_fs_id expected %h got %h",
                                 $time, e.mfid, match_fs_id);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                c.op = op_t'(op);
                c.kind = kind_t'(id_kind);
                c.dir = direction;
                c.cid = cli_id;
                c.fid = fs_id;
                c.sid = search_id;
                replies_due.push_back(predict_map_reply(c));
            end
            took_cmd <= start && !busy;
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top failed");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

endmodule

// ===== bidirectional_id_map_table.f =====
hw/rtl/bimt_pkg.sv
hw/rtl/bimt_cell.sv
hw/rtl/bidirectional_id_map_table.sv
test/tb_top.sv
